// ----- rtl/multi_key_autorepeat_assert.svh -----
// Assertion macros shared by the multi-key autorepeat RTL.
`ifndef MULTI_KEY_AUTOREPEAT_ASSERT_SVH
`define MULTI_KEY_AUTOREPEAT_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on the rising edge, quiet while reset is asserted.
`define MKA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("multi_key_autorepeat assertion failed");
// Checked on every rising edge, reset included.
`define MKA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("multi_key_autorepeat assertion failed");
`else
`define MKA_ASSERT(lbl, clk, rst_n, prop)
`define MKA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- rtl/mka_pkg.sv -----
// Package for the multi-key autorepeat block: widths, reset values, register indexes.
package mka_pkg;

    localparam int SLOTS_DEF   = 8;
    localparam int SLOT_W      = 3;
    localparam int PAD_W       = 32;
    localparam int RELOAD_W    = 5;
    localparam int HOLD_W      = 4;
    localparam int TIMER_W     = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [RELOAD_W-1:0] RESET_REPEAT  = 5'd12;
    localparam logic [HOLD_W-1:0]   RESET_RELEASE = 4'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_RELOAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HOLD  = 2'd1;

    // Per-slot counters kept in the slot memory
    typedef struct packed {
        logic [HOLD_W-1:0]  release_count;
        logic [TIMER_W-1:0] repeat_timer;
    } t_ctr;

endpackage

// ----- rtl/multi_key_autorepeat.sv -----
// Top level of the multi-key autorepeat block.
// An event passes through stage 1 and then the output register after its tick transaction is accepted.
// Throughput: one tick per cycle when the output does not stall; the counter memory
// read-modify-write overlaps the next read through a one-entry forward path.
// Reset (synchronous, active low) clears all slot marks and restores both registers;
// the counter memory needs no clearing pass since counters of unmarked slots are unused.
`include "multi_key_autorepeat_assert.svh"
module multi_key_autorepeat #(
    parameter int SLOTS = mka_pkg::SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration writes
    input  logic                              i_cfg_we,
    input  logic [mka_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mka_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Tick input
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [mka_pkg::SLOT_W-1:0]        i_slot,
    input  logic [mka_pkg::PAD_W-1:0]         i_pad,
    input  logic [mka_pkg::PAD_W-1:0]         i_key_mask,
    // Event output
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [mka_pkg::SLOT_W-1:0]        o_event_slot
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Configuration registers
    logic [mka_pkg::RELOAD_W-1:0] r_repeat_reload;
    logic [mka_pkg::HOLD_W-1:0]   r_release_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_reload <= mka_pkg::RESET_REPEAT;
            r_release_hold  <= mka_pkg::RESET_RELEASE;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == mka_pkg::CFG_REPEAT_RELOAD) begin
                r_repeat_reload <= i_cfg_data[mka_pkg::RELOAD_W-1:0];
            end else if (i_cfg_idx == mka_pkg::CFG_RELEASE_HOLD) begin
                r_release_hold <= i_cfg_data[mka_pkg::HOLD_W-1:0];
            end
        end
    end

    // Handshake
    logic                        r_s1_valid;
    logic [mka_pkg::SLOT_W-1:0]  r_s1_slot;
    logic [AW-1:0]               r_s1_addr;
    logic                        r_s1_down;
    logic                        r_s1_inr;
    logic                        r_out_valid;
    logic [mka_pkg::SLOT_W-1:0]  r_out_slot;
    logic                        w_in_acc;
    logic                        w_s1_adv;
    logic                        w_in_range;
    logic [AW-1:0]               w_addr;

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall    = r_s1_valid && !w_s1_adv;
    assign w_in_acc   = i_valid && !o_stall;
    assign w_in_range = ({{(32 - mka_pkg::SLOT_W){1'b0}}, i_slot} < 32'(SLOTS));
    assign w_addr     = AW'(i_slot);

    // Stage 1: tick waits for its counter read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_slot <= i_slot;
            r_s1_addr <= w_addr;
            r_s1_down <= |(i_pad & i_key_mask);
            r_s1_inr  <= w_in_range;
        end
    end

    // Counter memory
    mka_pkg::t_ctr w_ctr_cur;
    mka_pkg::t_ctr n_ctr;
    logic          w_we;

    mka_ctr_ram #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_ctr_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (w_addr),
        .i_wr_en   (w_we),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (n_ctr),
        .o_rd_data (w_ctr_cur)
    );

    // Slot marks live in flops so reset clears them at once
    logic r_marked [SLOTS];
    logic w_marked;
    logic n_marked;
    logic w_upd;
    logic w_event;

    assign w_marked = r_marked[r_s1_addr];

    // Per-slot update
    always_comb begin
        n_ctr    = w_ctr_cur;
        n_marked = w_marked;
        w_upd    = 1'b0;
        w_event  = 1'b0;
        if (r_s1_valid && r_s1_inr) begin
            if (r_s1_down) begin
                w_upd = 1'b1;
                if (w_marked) begin
                    if (w_ctr_cur.repeat_timer != '0) begin
                        n_ctr.repeat_timer = w_ctr_cur.repeat_timer - 1'b1;
                    end else begin
                        n_ctr.repeat_timer = {1'b0, r_repeat_reload};
                        w_event            = 1'b1;
                    end
                end else begin
                    n_marked            = 1'b1;
                    n_ctr.repeat_timer  = {1'b0, r_repeat_reload};
                    n_ctr.release_count = r_release_hold;
                    w_event             = 1'b1;
                end
            end else if (w_marked) begin
                w_upd              = 1'b1;
                n_ctr.repeat_timer = {1'b0, r_repeat_reload};
                if (w_ctr_cur.release_count != '0) begin
                    n_ctr.release_count = w_ctr_cur.release_count - 1'b1;
                end else begin
                    n_marked            = 1'b0;
                    n_ctr.release_count = r_release_hold;
                end
            end
        end
    end

    assign w_we = w_upd && w_s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_marked[i] <= 1'b0;
            end
        end else if (w_we) begin
            r_marked[r_s1_addr] <= n_marked;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= w_event;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && w_event) begin
            r_out_slot <= r_s1_slot;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_event_slot = r_out_slot;

    // Events only come from in-range down ticks
    `MKA_ASSERT(a_event_src, i_clk, i_rst_n, w_event |-> (r_s1_valid && r_s1_inr && r_s1_down))
    // A down tick leaves its slot marked
    `MKA_ASSERT(a_down_marks, i_clk, i_rst_n, (w_we && r_s1_down) |=> r_marked[$past(r_s1_addr)])
    // An event moves into the output register with its slot
    `MKA_ASSERT(a_event_out, i_clk, i_rst_n, (w_s1_adv && w_event) |=> (o_valid && (o_event_slot == $past(r_s1_slot))))
    // Input is never held off while stage 1 is empty
    `MKA_ASSERT_ALWAYS(a_stall_empty, i_clk, !r_s1_valid |-> !o_stall)

endmodule

// ----- rtl/mka_ctr_ram.sv -----
// Slot counter memory: synchronous read, one write port, write-to-read forwarding.
module mka_ctr_ram #(
    parameter int SLOTS = mka_pkg::SLOTS_DEF,
    parameter int AW    = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  mka_pkg::t_ctr   i_wr_data,
    output mka_pkg::t_ctr   o_rd_data
);

    mka_pkg::t_ctr r_mem [SLOTS];
    mka_pkg::t_ctr r_rd_data;
    mka_pkg::t_ctr r_fwd_data;
    logic          r_fwd_hit;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; a write landing on the same edge is captured for bypass
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the multi-key autorepeat block.
`timescale 1ns / 1ps

module tb_top;
    import mka_pkg::*;

    // Indexes past the end of the register list; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

    localparam int RANDOM_FIRST   = 300;
    localparam int RANDOM_PER_SET = 330;
    localparam int NUM_SETTINGS   = 5;
    localparam int IDLE_LIMIT     = 5000;
    localparam int HOLD_OFF_AT    = 600;
    localparam int HOLD_OFF_LEN   = 300;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [PAD_W-1:0]  pad;
        logic [PAD_W-1:0]  mask;
    } tick_t;

    // DUT connections
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_REPEAT_RELOAD;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [SLOT_W-1:0]     i_slot = '0;
    logic [PAD_W-1:0]      i_pad = '0;
    logic [PAD_W-1:0]      i_key_mask = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [SLOT_W-1:0]     o_event_slot;

    multi_key_autorepeat uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_slot       (i_slot),
        .i_pad        (i_pad),
        .i_key_mask   (i_key_mask),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_slot (o_event_slot)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predicted per-slot state and register copies
    logic [RELOAD_W-1:0] reload_cfg = RESET_REPEAT;
    logic [HOLD_W-1:0]   hold_cfg = RESET_RELEASE;
    logic                key_marked [SLOTS_DEF];
    logic [HOLD_W-1:0]   release_left [SLOTS_DEF];
    logic [TIMER_W-1:0]  repeat_left [SLOTS_DEF];

    tick_t             pending_ticks [$];
    logic [SLOT_W-1:0] pending_events [$];

    int  err_count = 0;
    int  ticks_in = 0;
    int  events_seen = 0;
    bit  tick_taken = 1'b0;

    // Stimulus script per slot: press or release run with frames left
    bit  script_down [SLOTS_DEF];
    int  script_left [SLOTS_DEF];

    initial begin
        for (int s = 0; s < SLOTS_DEF; s++) begin
            key_marked[s] = 1'b0;
            release_left[s] = RESET_RELEASE;
            repeat_left[s] = TIMER_W'(RESET_REPEAT);
            script_down[s] = 1'b0;
            script_left[s] = 0;
        end
    end

    // One frame tick; returns 1 when the slot raises an event
    function automatic bit autorepeat_step(input tick_t t);
        bit down;
        int s;
        s = int'(t.slot);
        down = (t.pad & t.mask) != '0;
        if (s >= SLOTS_DEF)
            return 1'b0;
        if (!down) begin
            if (key_marked[s]) begin
                if (release_left[s] != '0) begin
                    release_left[s] = release_left[s] - 1'b1;
                    repeat_left[s] = TIMER_W'(reload_cfg);
                end else begin
                    // release frame: unmark and restamp both counters
                    key_marked[s] = 1'b0;
                    repeat_left[s] = TIMER_W'(reload_cfg);
                    release_left[s] = hold_cfg;
                end
            end
            return 1'b0;
        end
        if (key_marked[s]) begin
            if (repeat_left[s] != '0) begin
                repeat_left[s] = repeat_left[s] - 1'b1;
                return 1'b0;
            end
            repeat_left[s] = TIMER_W'(reload_cfg);
        end else begin
            key_marked[s] = 1'b1;
            repeat_left[s] = TIMER_W'(reload_cfg);
            release_left[s] = hold_cfg;
        end
        return 1'b1;
    endfunction

    // Random pad word and mask that read as down or up
    function automatic tick_t make_tick(input logic [SLOT_W-1:0] s, input bit down);
        tick_t t;
        int b;
        t.slot = s;
        t.pad = $urandom;
        t.mask = $urandom;
        case ($urandom_range(0, 7))
            0: t.mask = '1;
            1: t.mask = PAD_W'(1) << $urandom_range(0, PAD_W - 1);
            2: t.pad = '1;
            default: ;
        endcase
        if (down) begin
            b = $urandom_range(0, PAD_W - 1);
            t.mask[b] = 1'b1;
            t.pad[b] = 1'b1;
        end else begin
            t.pad = t.pad & ~t.mask;
        end
        return t;
    endfunction

    // Mostly well-formed press/hold/release runs per slot, interleaved, plus noise
    task automatic queue_random(input int n);
        tick_t t;
        int s;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 12) begin
                t.slot = SLOT_W'($urandom);
                t.pad = $urandom;
                t.mask = $urandom;
            end else begin
                s = $urandom_range(0, SLOTS_DEF - 1);
                if (script_left[s] == 0) begin
                    script_down[s] = !script_down[s];
                    if (script_down[s])
                        script_left[s] = $urandom_range(1, 2 * (int'(reload_cfg) + 1) + 2);
                    else
                        script_left[s] = $urandom_range(1, int'(hold_cfg) + 3);
                end
                script_left[s]--;
                t = make_tick(SLOT_W'(s), script_down[s]);
            end
            pending_ticks.push_back(t);
        end
    endtask

    task automatic queue_tick(input logic [SLOT_W-1:0] s, input logic [PAD_W-1:0] pad,
                              input logic [PAD_W-1:0] mask);
        tick_t t;
        t.slot = s;
        t.pad = pad;
        t.mask = mask;
        pending_ticks.push_back(t);
    endtask

    task automatic report_mismatch(input string what, input logic [SLOT_W-1:0] want,
                                   input logic [SLOT_W-1:0] got);
        $display("MISMATCH t=%0t %s: expected slot %0d, got %0d", $realtime, what, want, got);
        err_count++;
    endtask

    // Register write; the block is idle whenever this is called
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_REPEAT_RELOAD: reload_cfg = RELOAD_W'(data);
            CFG_RELEASE_HOLD:  hold_cfg = HOLD_W'(data);
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() != 0 || i_valid)
            @(negedge i_clk);
        // the last tick may still be offered or in the pipeline
        repeat (4) @(negedge i_clk);
        while (pending_events.size() != 0 || o_valid)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // Sender: bursts of random length separated by random gaps
    int    burst_left = 8;
    int    gap_left = 0;
    tick_t next_tick;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !tick_taken) begin
            // stalled: hold the payload
        end else if (gap_left != 0) begin
            gap_left--;
            i_valid <= 1'b0;
        end else if (pending_ticks.size() == 0) begin
            i_valid <= 1'b0;
        end else begin
            next_tick = pending_ticks.pop_front();
            i_valid <= 1'b1;
            i_slot <= next_tick.slot;
            i_pad <= next_tick.pad;
            i_key_mask <= next_tick.mask;
            burst_left--;
            if (burst_left <= 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    burst_left = $urandom_range(40, 80);
                    gap_left = 0;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = $urandom_range(1, 5);
                end
            end
        end
    end

    // Receiver: stall pattern steps through four modes, plus one long hold-off
    int stall_cycle = 0;
    int hold_off_left = 0;
    bit hold_off_done = 1'b0;

    always @(negedge i_clk) begin
        stall_cycle++;
        if (!hold_off_done && ticks_in >= HOLD_OFF_AT) begin
            hold_off_done = 1'b1;
            hold_off_left = HOLD_OFF_LEN;
        end
        if (hold_off_left != 0) begin
            hold_off_left--;
            i_stall <= 1'b1;
        end else begin
            case ((stall_cycle >> 6) % 4)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= stall_cycle[1];
            endcase
        end
    end

    // Monitor: predict on each accepted tick, check each accepted event
    always @(posedge i_clk) begin
        tick_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            ticks_in++;
            if (autorepeat_step({i_slot, i_pad, i_key_mask}))
                pending_events.push_back(i_slot);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            events_seen++;
            if (pending_events.size() == 0)
                report_mismatch("event with none expected", '0, o_event_slot);
            else if (o_event_slot !== pending_events[0])
                report_mismatch("event_slot", pending_events.pop_front(), o_event_slot);
            else
                void'(pending_events.pop_front());
        end
    end

    // Watchdog on cycles with no transaction on either side
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sequencing: reset, directed ticks, then random phases over register settings
    logic [RELOAD_W-1:0] reload_set [NUM_SETTINGS] = '{5'd0, 5'd31, 5'd5, 5'd1, 5'd20};
    logic [HOLD_W-1:0]   hold_set [NUM_SETTINGS]   = '{4'd0, 4'd15, 4'd2, 4'd15, 4'd7};

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: repeat every 13 held frames, release after 3 extra up frames
        queue_tick(3'd0, 32'hffff_ffff, 32'h0000_0000);  // up on an unmarked slot
        queue_tick(3'd0, 32'h0000_0001, 32'h0000_0001);  // first press
        queue_tick(3'd0, 32'h0000_0000, 32'hffff_ffff);  // up, release count runs
        queue_tick(3'd0, 32'h8000_0000, 32'h8000_0000);  // down again before release
        queue_tick(3'd7, 32'hffff_ffff, 32'hffff_ffff);  // press on the top slot
        for (int k = 0; k < 13; k++)
            queue_tick(3'd7, $urandom | 32'h0000_0100, 32'h0000_0100);  // held to a repeat
        for (int k = 0; k < 4; k++)
            queue_tick(3'd7, 32'h0000_0000, $urandom);    // last one is the release frame
        queue_tick(3'd7, 32'h5555_5555, 32'haaaa_aaaa);  // up after release
        queue_tick(3'd7, 32'haaaa_aaaa, 32'haaaa_aaaa);  // new press
        queue_random(RANDOM_FIRST);
        wait_drained();

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            write_reg(CFG_REPEAT_RELOAD, CFG_DATA_W'(reload_set[p]));
            write_reg(CFG_RELEASE_HOLD, CFG_DATA_W'(hold_set[p]));
            if (p == 2) begin
                write_reg(CFG_UNUSED_A, 5'h1f);
                write_reg(CFG_UNUSED_B, 5'h00);
            end
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            queue_random(RANDOM_PER_SET);
            wait_drained();
        end

        repeat (6) @(negedge i_clk);
        $display("Covered %0d ticks over %0d register settings plus reset values,",
                 ticks_in, NUM_SETTINGS);
        $display("with %0d key events checked and %0d mismatches.", events_seen, err_count);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mka_pkg.sv
rtl/mka_ctr_ram.sv
rtl/multi_key_autorepeat.sv
tb/sv/tb_top.sv
